FILE: src/dct_quantize_8x8_defines.svh
// Assertion macros for the 8x8 DCT quantizer.
`ifndef DCT_QUANTIZE_8X8_DEFINES_SVH
`define DCT_QUANTIZE_8X8_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DCQ_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("dcq: assertion failed");
`define DCQ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("dcq: assertion failed");
`else
`define DCQ_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define DCQ_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: src/dcq_pkg.sv
// Shared types, tables and basis function of the 8x8 DCT quantizer.
package dcq_pkg;

	localparam int COS_FRAC_BITS_DEF = 14;
	localparam int SAMPLE_W = 8;
	localparam int COEF_W = 9;
	localparam int ROW_W = 20;
	localparam int OUT_SHIFT = 20;

	localparam logic [6:0] QTAB [64] = '{
		7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
		7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
		7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
		7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
		7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
		7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
		7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
		7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
	};

	// cos(k*pi/16) in Q30
	localparam longint COS_Q30 [9] = '{
		64'sd1073741824, 64'sd1053110176, 64'sd992008094, 64'sd892783698,
		64'sd759250125, 64'sd596538995, 64'sd410903207, 64'sd209476638, 64'sd0
	};

	typedef struct packed {
		logic       avail;
		logic [1:0] fill;
	} f2b_t;

	typedef struct packed {
		logic [5:0] rd_addr;
		logic       rel;
	} b2f_t;

	// C(u)/2 * cos((2m+1)u*pi/16) with f fraction bits
	function automatic int basis_val(int u, int m, int f);
		longint master;
		longint mag;
		int k;
		bit neg;
		neg = 1'b0;
		master = COS_Q30[4];
		if (u != 0) begin
			k = ((2 * m + 1) * u) & 31;
			if (k > 16) k = 32 - k;
			if (k > 8) begin
				k = 16 - k;
				neg = 1'b1;
			end
			master = COS_Q30[k];
		end
		mag = (master + (longint'(1) << (30 - f))) >>> (31 - f);
		return neg ? int'(-mag) : int'(mag);
	endfunction

endpackage

FILE: src/dcq_ifs.sv
// Stream interfaces for samples in and coefficients out.
interface dcq_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dcq_pkg::SAMPLE_W-1:0]    sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface dcq_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dcq_pkg::COEF_W-1:0]      coefficient;
	logic                                   last_in_block;
	modport source (output valid, output coefficient, output last_in_block, input ready);
	modport sink (input valid, input coefficient, input last_in_block, output ready);
endinterface

FILE: src/dct_quantize_8x8.sv
// Throughput is set by the single MAC, which forms each row and column output in turn,
// and by the serial quantizing divide that follows each column output.
// Intake takes one sample per cycle until both block banks are full.
// Reset: arst_n clears the sample count, bank queue and sequencer; buffers are not cleared.
module dct_quantize_8x8 #(
	parameter int COS_FRAC_BITS = dcq_pkg::COS_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dcq_in_if.sink     pixels,
	dcq_out_if.source  coefs
);

	`include "dct_quantize_8x8_defines.svh"

	dcq_pkg::f2b_t f2b;
	dcq_pkg::b2f_t b2f;
	logic signed [dcq_pkg::SAMPLE_W-1:0] smp_data;

	dcq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixels),
		.b2f     (b2f),
		.f2b     (f2b),
		.rd_data (smp_data)
	);

	dcq_back #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.f2b      (f2b),
		.b2f      (b2f),
		.smp_data (smp_data),
		.coefs    (coefs)
	);

	`DCQ_ASSERT_IMPLY(a_rel_avail, clk, arst_n, b2f.rel, f2b.avail)
	`DCQ_ASSERT_IMPLY(a_out_avail, clk, arst_n, coefs.valid, f2b.avail)
	`DCQ_ASSERT_IMPLY(a_stall_full, clk, arst_n, !pixels.ready, f2b.fill == 2'd2)
	`DCQ_ASSERT_NEXT(a_rel_idle, clk, arst_n, b2f.rel, !coefs.valid)

endmodule

FILE: src/dcq_front.sv
// Sample intake: two block banks and the block queue toward the transform engine.
module dcq_front (
	input  logic                               clk,
	input  logic                               arst_n,
	dcq_in_if.sink                             pixels,
	input  dcq_pkg::b2f_t                      b2f,
	output dcq_pkg::f2b_t                      f2b,
	output logic signed [dcq_pkg::SAMPLE_W-1:0] rd_data
);

	logic signed [dcq_pkg::SAMPLE_W-1:0] mem [128];
	logic [5:0] cnt_q;
	logic       wr_bank_q;
	logic       rd_bank_q;
	logic [1:0] full_q;
	logic [1:0] full_d;
	logic       accept;

	assign pixels.ready = !full_q[wr_bank_q];
	assign accept = pixels.valid && pixels.ready;
	assign f2b.avail = full_q[rd_bank_q];
	assign f2b.fill = 2'(full_q[0]) + 2'(full_q[1]);

	always_comb begin
		full_d = full_q;
		if (b2f.rel) full_d[rd_bank_q] = 1'b0;
		if (accept && cnt_q == 6'd63) full_d[wr_bank_q] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
			full_q <= '0;
		end else begin
			full_q <= full_d;
			if (accept) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) wr_bank_q <= !wr_bank_q;
			end
			if (b2f.rel) rd_bank_q <= !rd_bank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) mem[{wr_bank_q, cnt_q}] <= pixels.sample;
		rd_data <= mem[{rd_bank_q, b2f.rd_addr}];
	end

endmodule

FILE: src/dcq_back.sv
// Transform engine: row and column passes on one MAC, with a serial quantizing divide after each column output.
module dcq_back #(
	parameter int COS_FRAC_BITS = dcq_pkg::COS_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dcq_pkg::f2b_t                      f2b,
	output dcq_pkg::b2f_t                      b2f,
	input  logic signed [dcq_pkg::SAMPLE_W-1:0] smp_data,
	dcq_out_if.source                          coefs
);

	localparam int BW = COS_FRAC_BITS + 1;
	localparam int PW = dcq_pkg::ROW_W + BW;
	localparam int AW = PW + 3;
	localparam int RS = 2 * COS_FRAC_BITS - 20;
	localparam logic signed [AW-1:0] RND = AW'(1) <<< (RS - 1);
	localparam logic signed [AW-1:0] R_MAX = (AW'(1) <<< (dcq_pkg::ROW_W - 1)) - AW'(1);
	localparam logic signed [AW-1:0] R_MIN = -(AW'(1) <<< (dcq_pkg::ROW_W - 1));

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ROW  = 5'b00010,
		ST_COL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} bst_t;

	bst_t st_q;
	logic [5:0] idx_q;
	logic [3:0] term_q;
	logic [3:0] cnt_q;
	logic issue;

	logic v_s1, last_s1, first_s1;
	logic [2:0] tm_s1;
	logic v_s2, last_s2, first_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;

	logic signed [dcq_pkg::ROW_W-1:0] rowmem [64];
	logic signed [dcq_pkg::ROW_W-1:0] rowmem_q;

	logic [2:0] bu;
	int bval;
	logic signed [BW-1:0] basis;
	logic signed [dcq_pkg::ROW_W-1:0] opnd;
	logic signed [AW-1:0] sum;
	logic signed [AW-1:0] rsh;
	logic signed [dcq_pkg::ROW_W-1:0] r20;
	logic [AW-1:0] magn;
	logic [AW-1:0] fm;
	logic [11:0] fmag;

	logic [11:0] dq_q;
	logic [7:0] rem_q;
	logic neg_q;
	logic [7:0] trial;
	logic [6:0] qv;
	logic ge;
	logic [8:0] coef_d;
	logic signed [dcq_pkg::COEF_W-1:0] coef_q;
	logic last_q;
	logic out_take;

	assign issue = (st_q == ST_ROW || st_q == ST_COL) && !term_q[3];
	assign b2f.rd_addr = {idx_q[5:3], term_q[2:0]};
	assign out_take = (st_q == ST_OUT) && coefs.ready;
	assign b2f.rel = out_take && idx_q == 6'd63;
	assign coefs.valid = (st_q == ST_OUT);
	assign coefs.coefficient = coef_q;
	assign coefs.last_in_block = last_q;

	always_comb begin
		bu = (st_q == ST_ROW) ? idx_q[2:0] : idx_q[5:3];
		bval = dcq_pkg::basis_val(int'(bu), int'(tm_s1), COS_FRAC_BITS);
		basis = bval[BW-1:0];
		opnd = (st_q == ST_ROW) ? dcq_pkg::ROW_W'(smp_data) : rowmem_q;
		sum = (first_s2 ? '0 : acc_q) + AW'(prod_s2);
		rsh = (sum + RND) >>> RS;
		if (rsh > R_MAX) r20 = R_MAX[dcq_pkg::ROW_W-1:0];
		else if (rsh < R_MIN) r20 = R_MIN[dcq_pkg::ROW_W-1:0];
		else r20 = rsh[dcq_pkg::ROW_W-1:0];
		magn = sum[AW-1] ? AW'(-sum) : AW'(sum);
		fm = magn >> dcq_pkg::OUT_SHIFT;
		fmag = (|fm[AW-1:12]) ? 12'hFFF : fm[11:0];
		qv = dcq_pkg::QTAB[idx_q];
		trial = {rem_q[6:0], dq_q[11]};
		ge = trial >= {1'b0, qv};
		if (neg_q) coef_d = (|dq_q[11:8]) ? 9'h100 : 9'd0 - {1'b0, dq_q[7:0]};
		else coef_d = (|dq_q[11:8]) ? 9'd255 : {1'b0, dq_q[7:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			term_q <= '0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) term_q <= term_q + 4'd1;
			unique case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					term_q <= '0;
					if (f2b.avail) st_q <= ST_ROW;
				end
				ST_ROW: begin
					if (v_s2 && last_s2) begin
						term_q <= '0;
						idx_q <= idx_q + 6'd1;
						if (idx_q == 6'd63) st_q <= ST_COL;
					end
				end
				ST_COL: begin
					if (v_s2 && last_s2) begin
						cnt_q <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd12) st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (coefs.ready) begin
						term_q <= '0;
						idx_q <= idx_q + 6'd1;
						st_q <= (idx_q == 6'd63) ? ST_IDLE : ST_COL;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: MAC pipeline, row store, divider, output register
	always_ff @(posedge clk) begin
		last_s1 <= term_q == 4'd7;
		first_s1 <= term_q == 4'd0;
		tm_s1 <= term_q[2:0];
		last_s2 <= last_s1;
		first_s2 <= first_s1;
		prod_s2 <= opnd * basis;
		if (v_s2) acc_q <= sum;
		rowmem_q <= rowmem[{term_q[2:0], idx_q[2:0]}];
		if (st_q == ST_ROW && v_s2 && last_s2) rowmem[idx_q] <= r20;
		if (st_q == ST_COL && v_s2 && last_s2) begin
			dq_q <= fmag;
			rem_q <= '0;
			neg_q <= sum[AW-1];
		end
		if (st_q == ST_DIV) begin
			if (cnt_q == 4'd12) begin
				coef_q <= coef_d;
				last_q <= idx_q == 6'd63;
			end else begin
				rem_q <= ge ? trial - {1'b0, qv} : trial;
				dq_q <= {dq_q[10:0], ge};
			end
		end
	end

endmodule
